// ----- sv/ksa_pkg.sv -----
// Shared types and constants for the keyed sequence allocator.
package ksa_pkg;

    localparam int unsigned OP_W  = 2;
    localparam int unsigned KIND_W = 8;
    localparam int unsigned ID_W  = 64;
    localparam int unsigned SEQ_W = 64;
    localparam int unsigned KEY_W = KIND_W + ID_W;

    localparam int unsigned TABLE_DEPTH_DEF = 64;
    localparam int unsigned QUEUE_DEPTH     = 2;

    localparam logic [SEQ_W-1:0] SEQ_ALL_ONES = {SEQ_W{1'b1}};
    localparam logic [SEQ_W-1:0] SEQ_ZERO     = '0;

    // Operation codes on the input beat; code 3 is unused.
    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_KEYED   = 2'd1,
        OP_OBSERVE = 2'd2
    } op_t;

    // Work class decided by the front end.
    typedef enum logic [1:0] {
        CLS_ALLOC,
        CLS_KEYED,
        CLS_OBSERVE,
        CLS_IGNORE
    } cls_t;

    typedef struct packed {
        cls_t              cls;
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [SEQ_W-1:0]  seen;
    } item_t;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic             hit;
        logic             full;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_RESULT
    } state_t;

    // Handshake between a queue and the engine.
    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

// ----- sv/ksa_fifo.sv -----
// Small register-based queue used for the work and result queues.
module ksa_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = ksa_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output ksa_pkg::q_status_t status,
    output logic [WIDTH-1:0] rdata
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_C  = PW'(DEPTH - 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign status.empty = (cnt_reg == '0);
    assign status.full  = (cnt_reg == DEPTH_C);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign rdata        = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_C) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_C) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- sv/ksa_front.sv -----
// Front end: accepts request beats, classifies them and queues them for the engine.
module ksa_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic [ksa_pkg::OP_W-1:0]     operation,
    input  logic [ksa_pkg::KIND_W-1:0]   event_type,
    input  logic [ksa_pkg::ID_W-1:0]     object_id,
    input  logic [ksa_pkg::SEQ_W-1:0]    seen_sequence,
    input  logic                         q_pop,
    output ksa_pkg::q_status_t           q_status,
    output ksa_pkg::item_t               q_item
);

    ksa_pkg::item_t     in_item;
    ksa_pkg::q_status_t fifo_status;
    logic [$bits(ksa_pkg::item_t)-1:0] fifo_rdata;

    always_comb
    begin
        in_item.kind = event_type;
        in_item.id   = object_id;
        in_item.seen = seen_sequence;
        case (operation)
            ksa_pkg::OP_ALLOC:   in_item.cls = ksa_pkg::CLS_ALLOC;
            // a keyed request with no object does nothing
            ksa_pkg::OP_KEYED:   in_item.cls = (object_id != '0) ? ksa_pkg::CLS_KEYED
                                                                 : ksa_pkg::CLS_IGNORE;
            ksa_pkg::OP_OBSERVE: in_item.cls = ksa_pkg::CLS_OBSERVE;
            default:             in_item.cls = ksa_pkg::CLS_IGNORE;
        endcase
    end

    ksa_fifo #(
        .WIDTH ($bits(ksa_pkg::item_t)),
        .DEPTH (ksa_pkg::QUEUE_DEPTH)
    ) u_work_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  (in_item),
        .pop    (q_pop),
        .status (fifo_status),
        .rdata  (fifo_rdata)
    );

    assign full     = fifo_status.full;
    assign q_status = fifo_status;
    assign q_item   = ksa_pkg::item_t'(fifo_rdata);

endmodule

// ----- sv/ksa_engine.sv -----
// Back end: sequence counter, key table search and result generation.
module ksa_engine #(
    parameter int unsigned TABLE_DEPTH = ksa_pkg::TABLE_DEPTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ksa_pkg::q_status_t q_status,
    input  ksa_pkg::item_t     q_item,
    output logic               q_pop,
    input  ksa_pkg::q_status_t out_status,
    output logic               out_push,
    output ksa_pkg::result_t   out_res
);

    localparam int unsigned IW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    ksa_pkg::state_t  state_reg, state_next;
    logic [ksa_pkg::SEQ_W-1:0] counter_reg, counter_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    issue_reg, issue_next;
    logic             cmp_valid_reg, cmp_valid_next;
    ksa_pkg::item_t   cur_reg, cur_next;
    ksa_pkg::result_t res_reg, res_next;

    logic [ksa_pkg::KEY_W-1:0] key_mem [TABLE_DEPTH];
    logic [ksa_pkg::SEQ_W-1:0] seq_mem [TABLE_DEPTH];
    logic [ksa_pkg::KEY_W-1:0] rd_key_reg;
    logic [ksa_pkg::SEQ_W-1:0] rd_seq_reg;

    logic                      mem_re, mem_we;
    logic                      can_alloc;
    logic [ksa_pkg::KEY_W-1:0] cur_key;

    assign can_alloc = (counter_reg != ksa_pkg::SEQ_ZERO)
                    && (counter_reg != ksa_pkg::SEQ_ALL_ONES);
    assign cur_key   = {cur_reg.kind, cur_reg.id};
    assign out_res   = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        counter_next   = counter_reg;
        count_next     = count_reg;
        issue_next     = issue_reg;
        cmp_valid_next = 1'b0;
        cur_next       = cur_reg;
        res_next       = res_reg;
        q_pop          = 1'b0;
        out_push       = 1'b0;
        mem_re         = 1'b0;
        mem_we         = 1'b0;
        case (state_reg)
            ksa_pkg::ST_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop      = 1'b1;
                    cur_next   = q_item;
                    res_next   = '0;
                    state_next = ksa_pkg::ST_RESULT;
                    case (q_item.cls)
                        ksa_pkg::CLS_ALLOC:
                        begin
                            if (can_alloc)
                            begin
                                res_next.seq = counter_reg;
                                counter_next = counter_reg + 1'b1;
                            end
                        end
                        ksa_pkg::CLS_KEYED:
                        begin
                            issue_next = '0;
                            state_next = ksa_pkg::ST_SEARCH;
                        end
                        ksa_pkg::CLS_OBSERVE:
                        begin
                            if (q_item.seen != ksa_pkg::SEQ_ZERO && q_item.seen >= counter_reg)
                            begin
                                // all ones wraps to zero: counter exhausted
                                counter_next = q_item.seen + 1'b1;
                            end
                        end
                        default:
                        begin
                            res_next = '0;
                        end
                    endcase
                end
            end
            ksa_pkg::ST_SEARCH:
            begin
                if (cmp_valid_reg && rd_key_reg == cur_key)
                begin
                    res_next.seq  = rd_seq_reg;
                    res_next.hit  = 1'b1;
                    res_next.full = 1'b0;
                    state_next    = ksa_pkg::ST_RESULT;
                end
                else if (issue_reg < count_reg)
                begin
                    mem_re         = 1'b1;
                    cmp_valid_next = 1'b1;
                    issue_next     = issue_reg + 1'b1;
                end
                else if (!cmp_valid_reg)
                begin
                    // miss: allocate and try to remember it
                    res_next   = '0;
                    state_next = ksa_pkg::ST_RESULT;
                    if (can_alloc)
                    begin
                        res_next.seq = counter_reg;
                        counter_next = counter_reg + 1'b1;
                        if (count_reg < DEPTH_C)
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        else
                        begin
                            res_next.full = 1'b1;
                        end
                    end
                end
            end
            ksa_pkg::ST_RESULT:
            begin
                if (!out_status.full)
                begin
                    out_push   = 1'b1;
                    state_next = ksa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ksa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ksa_pkg::ST_IDLE;
            counter_reg   <= ksa_pkg::SEQ_W'(1);
            count_reg     <= '0;
            issue_reg     <= '0;
            cmp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            counter_reg   <= counter_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            cmp_valid_reg <= cmp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            key_mem[count_reg[IW-1:0]] <= cur_key;
            seq_mem[count_reg[IW-1:0]] <= counter_reg;
        end
        if (mem_re)
        begin
            rd_key_reg <= key_mem[issue_reg[IW-1:0]];
            rd_seq_reg <= seq_mem[issue_reg[IW-1:0]];
        end
    end

endmodule

// ----- sv/keyed_sequence_allocator.sv -----
// Keyed sequence allocator top level: front end, engine and result queue.
//
// Usage:
//   Requests enter through a queue-style port: a beat is taken on a rising
//   edge with push high and full low. operation selects plain allocate,
//   keyed lookup-or-allocate (event_type, object_id) or observe
//   (seen_sequence). Every request yields exactly one result beat.
//   Results leave through a queue-style port: the oldest result is shown
//   while empty is low and is taken on an edge with pop high.
//
// Timing:
//   A plain allocate, observe or ignored request passes through the engine's
//   idle and result states. A keyed request walks the stored entries one per
//   cycle through a registered table read, and the engine stays busy until
//   it finds a hit or the stored entries run out. The two-beat work queue
//   keeps taking requests while the engine searches.
//
// Reset clears the counter to 1, the entry count to 0 and both queues;
// table contents are not cleared. When the receiver stalls, the result
// queue fills, the engine holds its finished result, and then the work
// queue fills and full rises. Nothing is dropped.
module keyed_sequence_allocator #(
    parameter int unsigned TABLE_DEPTH = ksa_pkg::TABLE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  logic [ksa_pkg::OP_W-1:0]   operation,
    input  logic [ksa_pkg::KIND_W-1:0] event_type,
    input  logic [ksa_pkg::ID_W-1:0]   object_id,
    input  logic [ksa_pkg::SEQ_W-1:0]  seen_sequence,
    output logic                       empty,
    input  logic                       pop,
    output logic [ksa_pkg::SEQ_W-1:0]  sequence_out,
    output logic                       was_remembered,
    output logic                       table_full
);

    ksa_pkg::q_status_t work_status;
    ksa_pkg::item_t     work_item;
    logic               work_pop;

    ksa_pkg::q_status_t res_status;
    ksa_pkg::result_t   eng_res;
    logic               eng_push;
    logic [$bits(ksa_pkg::result_t)-1:0] res_rdata;
    ksa_pkg::result_t   res_head;

    // Front end: classify and queue incoming beats
    ksa_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .operation     (operation),
        .event_type    (event_type),
        .object_id     (object_id),
        .seen_sequence (seen_sequence),
        .q_pop         (work_pop),
        .q_status      (work_status),
        .q_item        (work_item)
    );

    // Engine: counter plus key table search
    ksa_engine #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (work_status),
        .q_item     (work_item),
        .q_pop      (work_pop),
        .out_status (res_status),
        .out_push   (eng_push),
        .out_res    (eng_res)
    );

    // Result queue decouples the engine from a stalling receiver
    ksa_fifo #(
        .WIDTH ($bits(ksa_pkg::result_t)),
        .DEPTH (ksa_pkg::QUEUE_DEPTH)
    ) u_result_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (eng_push),
        .wdata  (eng_res),
        .pop    (pop),
        .status (res_status),
        .rdata  (res_rdata)
    );

    assign res_head       = ksa_pkg::result_t'(res_rdata);
    assign empty          = res_status.empty;
    assign sequence_out   = res_head.seq;
    assign was_remembered = res_head.hit;
    assign table_full     = res_head.full;

    // Only nonzero numbers are ever stored, so a hit never returns zero
    a_hit_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && was_remembered) |-> (sequence_out != ksa_pkg::SEQ_ZERO))
        else $error("remembered result carries zero sequence");

    // An overflow result still hands out a real number
    a_full_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && table_full) |-> (sequence_out != ksa_pkg::SEQ_ZERO))
        else $error("table_full result carries zero sequence");

    // A hit and an overflow cannot come from the same request
    a_hit_full_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> !(was_remembered && table_full))
        else $error("result flags both hit and table full");

    // Result side is empty right out of reset
    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> empty)
        else $error("result queue not empty after reset");

endmodule

// ----- test/tb_keyed_sequence_allocator.sv -----
// Testbench for the keyed sequence allocator: directed table, then random mixed traffic.
module tb_keyed_sequence_allocator;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned DEPTH       = ksa_pkg::TABLE_DEPTH_DEF;
    localparam int unsigned N_RANDOM    = 825;  // plus the directed rows, about 850 beats
    localparam int unsigned POOL_SIZE   = 48;   // recurring keys, so keyed lookups hit
    localparam int unsigned HOLD_AT     = 300;  // result count at which the long stall starts
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned DRAIN_WAIT  = DEPTH + 40;  // worst keyed search plus margin
    localparam int unsigned STALL_LIMIT = 3000;        // cycles with no beat on either side
    localparam int unsigned N_DIRECTED  = 25;

    // Code 3 is not in op_t; the block must treat it as a no-op.
    localparam logic [ksa_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [ksa_pkg::OP_W-1:0]   op;
        logic [ksa_pkg::KIND_W-1:0] kind;
        logic [ksa_pkg::ID_W-1:0]   id;
        logic [ksa_pkg::SEQ_W-1:0]  seen;
    } beat_t;

    // One directed row: the beat, and optionally the result typed in by hand.
    typedef struct packed {
        logic [ksa_pkg::OP_W-1:0]   op;
        logic [ksa_pkg::KIND_W-1:0] kind;
        logic [ksa_pkg::ID_W-1:0]   id;
        logic [ksa_pkg::SEQ_W-1:0]  seen;
        logic                       typed;
        logic [ksa_pkg::SEQ_W-1:0]  seq;
        logic                       hit;
        logic                       full;
    } dir_row_t;

    // Walks the special cases in order. The counter starts at 1 after reset.
    // Rows with typed = 0 are checked only against the predictor.
    localparam dir_row_t DIR_ROWS [N_DIRECTED] = '{
        // fresh counter: plain grant, keyed miss, keyed hit, keyed with no object
        '{ksa_pkg::OP_ALLOC,   8'h00, 64'h0, 64'h0, 1'b1, 64'd1, 1'b0, 1'b0},
        '{ksa_pkg::OP_KEYED,   8'h05, 64'h1234, 64'h0, 1'b1, 64'd2, 1'b0, 1'b0},
        '{ksa_pkg::OP_KEYED,   8'h05, 64'h1234, 64'h0, 1'b1, 64'd2, 1'b1, 1'b0},
        '{ksa_pkg::OP_KEYED,   8'h05, 64'h0, 64'h0, 1'b1, 64'd0, 1'b0, 1'b0},
        // unused code with every field at all ones: nothing happens
        '{OP_UNUSED,  8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
          1'b1, 64'd0, 1'b0, 1'b0},
        '{ksa_pkg::OP_ALLOC,   8'h00, 64'h0, 64'h0, 1'b1, 64'd3, 1'b0, 1'b0},
        // counter pushed to all ones: it can no longer grant
        '{ksa_pkg::OP_OBSERVE, 8'h00, 64'h0, 64'hFFFF_FFFF_FFFF_FFFE,
          1'b1, 64'd0, 1'b0, 1'b0},
        '{ksa_pkg::OP_ALLOC,   8'h00, 64'h0, 64'h0, 1'b1, 64'd0, 1'b0, 1'b0},
        // keyed miss on a dry counter: zero grant, nothing stored, no full flag
        '{ksa_pkg::OP_KEYED,   8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
          1'b1, 64'd0, 1'b0, 1'b0},
        // observing all ones exhausts the counter (zero)
        '{ksa_pkg::OP_OBSERVE, 8'h00, 64'h0, 64'hFFFF_FFFF_FFFF_FFFF,
          1'b1, 64'd0, 1'b0, 1'b0},
        '{ksa_pkg::OP_ALLOC,   8'h00, 64'h0, 64'h0, 1'b1, 64'd0, 1'b0, 1'b0},
        // a zero observation is ignored, a nonzero one revives the counter
        '{ksa_pkg::OP_OBSERVE, 8'h00, 64'h0, 64'h0, 1'b1, 64'd0, 1'b0, 1'b0},
        '{ksa_pkg::OP_OBSERVE, 8'h00, 64'h0, 64'h1, 1'b1, 64'd0, 1'b0, 1'b0},
        '{ksa_pkg::OP_ALLOC,   8'h00, 64'h0, 64'h0, 1'b1, 64'd2, 1'b0, 1'b0},
        // the key refused on the dry counter is a miss now, then a hit
        '{ksa_pkg::OP_KEYED,   8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
          1'b1, 64'd3, 1'b0, 1'b0},
        '{ksa_pkg::OP_KEYED,   8'hFF, 64'hFFFF_FFFF_FFFF_FFFF, 64'h0,
          1'b1, 64'd3, 1'b1, 1'b0},
        // same object, other kind: a separate key
        '{ksa_pkg::OP_KEYED,   8'h04, 64'h1234, 64'h0, 1'b0, 64'd0, 1'b0, 1'b0},
        // observation behind the counter: ignored
        '{ksa_pkg::OP_OBSERVE, 8'h00, 64'h0, 64'h3, 1'b0, 64'd0, 1'b0, 1'b0},
        '{ksa_pkg::OP_ALLOC,   8'h00, 64'h0, 64'h0, 1'b0, 64'd0, 1'b0, 1'b0},
        // jump to alternating bit patterns
        '{ksa_pkg::OP_OBSERVE, 8'h00, 64'h0, 64'hAAAA_AAAA_AAAA_AAAA,
          1'b1, 64'd0, 1'b0, 1'b0},
        '{ksa_pkg::OP_ALLOC,   8'h00, 64'h0, 64'h0,
          1'b1, 64'hAAAA_AAAA_AAAA_AAAB, 1'b0, 1'b0},
        '{ksa_pkg::OP_KEYED,   8'h00, 64'h5555_5555_5555_5555, 64'h0,
          1'b0, 64'd0, 1'b0, 1'b0},
        // top of the range: last grant before the counter sticks at all ones
        '{ksa_pkg::OP_OBSERVE, 8'h00, 64'h0, 64'hFFFF_FFFF_FFFF_FFFD,
          1'b1, 64'd0, 1'b0, 1'b0},
        '{ksa_pkg::OP_KEYED,   8'h00, 64'h5555_5555_5555_5555, 64'h0,
          1'b0, 64'd0, 1'b0, 1'b0},
        '{ksa_pkg::OP_ALLOC,   8'h00, 64'h0, 64'h0,
          1'b1, 64'hFFFF_FFFF_FFFF_FFFE, 1'b0, 1'b0}
    };

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       push = 1'b0;
    logic                       full;
    logic [ksa_pkg::OP_W-1:0]   operation = '0;
    logic [ksa_pkg::KIND_W-1:0] event_type = '0;
    logic [ksa_pkg::ID_W-1:0]   object_id = '0;
    logic [ksa_pkg::SEQ_W-1:0]  seen_sequence = '0;
    logic                       empty;
    logic                       pop = 1'b0;
    logic [ksa_pkg::SEQ_W-1:0]  sequence_out;
    logic                       was_remembered;
    logic                       table_full;

    keyed_sequence_allocator #(
        .TABLE_DEPTH(DEPTH)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .operation(operation),
        .event_type(event_type),
        .object_id(object_id),
        .seen_sequence(seen_sequence),
        .empty(empty),
        .pop(pop),
        .sequence_out(sequence_out),
        .was_remembered(was_remembered),
        .table_full(table_full)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Predictor state: the counter and the bounded key table.
    // ---------------------------------------------------------------
    logic [ksa_pkg::SEQ_W-1:0]  cnt_next;
    logic [ksa_pkg::KIND_W-1:0] tbl_kind [DEPTH];
    logic [ksa_pkg::ID_W-1:0]   tbl_id   [DEPTH];
    logic [ksa_pkg::SEQ_W-1:0]  tbl_seq  [DEPTH];
    int unsigned                tbl_used;

    // Results owed by the block, oldest first.
    ksa_pkg::result_t owed_grants [$];

    // Recurring keys for the random part.
    logic [ksa_pkg::KIND_W-1:0] pool_kind [POOL_SIZE];
    logic [ksa_pkg::ID_W-1:0]   pool_id   [POOL_SIZE];

    int errors = 0;
    int n_alloc = 0, n_keyed = 0, n_observe = 0, n_unused = 0;
    int n_hit = 0, n_full = 0, n_dry = 0;

    // Remaining zero-gap beats per side (0 sender, 1 receiver).
    int calm_left [2] = '{0, 0};

    // Gap before the next beat: drawn at random, with bursts of back-to-back beats.
    function automatic int draw_gap(input int side);
        if (calm_left[side] > 0)
        begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm_left[side] = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 14);
    endfunction

    // Next counter value; a counter at zero or all ones grants nothing.
    function automatic logic [ksa_pkg::SEQ_W-1:0] take_sequence();
        logic [ksa_pkg::SEQ_W-1:0] v;
        if (cnt_next == ksa_pkg::SEQ_ZERO || cnt_next == ksa_pkg::SEQ_ALL_ONES)
        begin
            n_dry++;
            return ksa_pkg::SEQ_ZERO;
        end
        v = cnt_next;
        cnt_next = cnt_next + 1'b1;
        return v;
    endfunction

    // Result of one accepted beat; updates counter and table.
    function automatic ksa_pkg::result_t grant_for(input beat_t b);
        ksa_pkg::result_t r;
        bit               found;
        int unsigned      i;
        r = '0;
        found = 1'b0;
        case (b.op)
            ksa_pkg::OP_ALLOC:
                r.seq = take_sequence();
            ksa_pkg::OP_KEYED:
                if (b.id != '0)
                begin
                    for (i = 0; i < tbl_used; i++)
                    begin
                        if (!found && tbl_kind[i] == b.kind && tbl_id[i] == b.id)
                        begin
                            r.seq = tbl_seq[i];
                            r.hit = 1'b1;
                            found = 1'b1;
                        end
                    end
                    if (!found)
                    begin
                        r.seq = take_sequence();
                        // a zero grant is never stored and never flags full
                        if (r.seq != ksa_pkg::SEQ_ZERO)
                        begin
                            if (tbl_used < DEPTH)
                            begin
                                tbl_kind[tbl_used] = b.kind;
                                tbl_id[tbl_used]   = b.id;
                                tbl_seq[tbl_used]  = r.seq;
                                tbl_used++;
                            end
                            else
                                r.full = 1'b1;
                        end
                    end
                end
            ksa_pkg::OP_OBSERVE:
                if (b.seen != ksa_pkg::SEQ_ZERO && b.seen >= cnt_next)
                    cnt_next = (b.seen == ksa_pkg::SEQ_ALL_ONES) ? ksa_pkg::SEQ_ZERO
                                                                  : b.seen + 1'b1;
            default:
                ;
        endcase
        return r;
    endfunction

    // Random beat, shaped by the predictor's current state so that the
    // counter keeps moving and keyed lookups both hit and miss.
    function automatic beat_t random_beat();
        beat_t b;
        int    pick;
        int    k;
        bit    dry;
        b.kind = ksa_pkg::KIND_W'($urandom_range(0, 255));
        b.id   = {$urandom, $urandom};
        b.seen = {$urandom, $urandom};
        dry    = (cnt_next == ksa_pkg::SEQ_ZERO || cnt_next == ksa_pkg::SEQ_ALL_ONES);
        pick   = $urandom_range(0, 99);
        // an exhausted counter gets revived often, otherwise the run goes stale
        if (dry && pick < 50)
            b.op = ksa_pkg::OP_OBSERVE;
        else if (pick < 30)
            b.op = ksa_pkg::OP_ALLOC;
        else if (pick < 75)
            b.op = ksa_pkg::OP_KEYED;
        else if (pick < 95)
            b.op = ksa_pkg::OP_OBSERVE;
        else
            b.op = OP_UNUSED;

        if (b.op == ksa_pkg::OP_KEYED)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 4)
                b.id = '0;
            else if (pick < 35 && tbl_used > 0)
            begin
                k = $urandom_range(0, tbl_used - 1);
                b.kind = tbl_kind[k];
                b.id   = tbl_id[k];
            end
            else if (pick < 70)
            begin
                k = $urandom_range(0, POOL_SIZE - 1);
                b.kind = pool_kind[k];
                b.id   = pool_id[k];
            end
            // else: a fresh random key
        end
        else if (b.op == ksa_pkg::OP_OBSERVE)
        begin
            pick = $urandom_range(0, 99);
            if (cnt_next == ksa_pkg::SEQ_ALL_ONES)
                b.seen = ksa_pkg::SEQ_ALL_ONES;
            else if (cnt_next == ksa_pkg::SEQ_ZERO)
                b.seen = ksa_pkg::SEQ_W'($urandom_range(1, 5000));
            else if (pick < 40)
                b.seen = cnt_next + ksa_pkg::SEQ_W'($urandom_range(0, 20));
            else if (pick < 55)
                b.seen = cnt_next - ksa_pkg::SEQ_W'($urandom_range(1, 8));
            else if (pick < 65)
                b.seen = ksa_pkg::SEQ_ZERO;
            else if (pick < 80)
                ;  // keep the full random value
            else if (pick < 90)
                b.seen = ksa_pkg::SEQ_ALL_ONES;
            else
                b.seen = ksa_pkg::SEQ_ALL_ONES - ksa_pkg::SEQ_W'($urandom_range(0, 3));
        end
        return b;
    endfunction

    // Offers one beat after a gap; called and returning at a falling edge.
    // A zero gap keeps push high, so push gets a single assignment per step.
    task automatic offer(input beat_t b, input int gap, input bit typed,
                         input ksa_pkg::result_t want);
        ksa_pkg::result_t got;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push          <= 1'b1;
        operation     <= b.op;
        event_type    <= b.kind;
        object_id     <= b.id;
        seen_sequence <= b.seen;
        do
            @(posedge clk);
        while (full);
        // accepted on this edge
        got = grant_for(b);
        owed_grants.push_back(typed ? want : got);
        case (b.op)
            ksa_pkg::OP_ALLOC:   n_alloc++;
            ksa_pkg::OP_KEYED:   n_keyed++;
            ksa_pkg::OP_OBSERVE: n_observe++;
            default:             n_unused++;
        endcase
        n_hit  += got.hit;
        n_full += got.full;
        @(negedge clk);
    endtask

    // ---------------------------------------------------------------
    // Sender: reset, directed table, random part, drain and verdict.
    // ---------------------------------------------------------------
    initial
    begin : feed_requests
        beat_t            b;
        ksa_pkg::result_t want;
        int               i;

        cnt_next = 64'd1;
        tbl_used = 0;
        for (i = 0; i < POOL_SIZE; i++)
        begin
            pool_kind[i] = ksa_pkg::KIND_W'($urandom_range(0, 255));
            pool_id[i]   = {$urandom, $urandom};
        end

        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (i = 0; i < N_DIRECTED; i++)
        begin
            b.op      = DIR_ROWS[i].op;
            b.kind    = DIR_ROWS[i].kind;
            b.id      = DIR_ROWS[i].id;
            b.seen    = DIR_ROWS[i].seen;
            want.seq  = DIR_ROWS[i].seq;
            want.hit  = DIR_ROWS[i].hit;
            want.full = DIR_ROWS[i].full;
            offer(b, draw_gap(0), DIR_ROWS[i].typed, want);
        end

        want = '0;
        for (i = 0; i < N_RANDOM; i++)
            offer(random_beat(), draw_gap(0), 1'b0, want);
        push <= 1'b0;

        // every beat is in; wait for all results, the watchdog bounds this
        while (owed_grants.size() != 0)
            @(posedge clk);
        // let any stray result surface
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("ran %0d beats: %0d allocate, %0d keyed, %0d observe, %0d unused code",
                 n_alloc + n_keyed + n_observe + n_unused, n_alloc, n_keyed, n_observe,
                 n_unused);
        $display("keyed hits %0d, refused for full table %0d, zero grants %0d, entries %0d",
                 n_hit, n_full, n_dry, tbl_used);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // ---------------------------------------------------------------
    // Receiver: pops with random gaps, one long hold to back the block up.
    // ---------------------------------------------------------------
    initial
    begin : take_results
        ksa_pkg::result_t want;
        int               gap;
        int               taken;
        bit               held;
        taken = 0;
        held  = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            gap = draw_gap(1);
            if (!held && taken == HOLD_AT)
            begin
                // both queues fill, then full stalls the sender
                held = 1'b1;
                gap  = HOLD_CYCLES;
            end
            if (gap > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            pop <= 1'b1;
            do
                @(posedge clk);
            while (empty);
            if (owed_grants.size() == 0)
            begin
                $display("%0t: result beat with nothing owed: seq %h remembered %b full %b",
                         $time, sequence_out, was_remembered, table_full);
                errors++;
            end
            else
            begin
                want = owed_grants.pop_front();
                if (sequence_out !== want.seq)
                begin
                    $display("%0t: sequence_out expected %h actual %h",
                             $time, want.seq, sequence_out);
                    errors++;
                end
                if (was_remembered !== want.hit)
                begin
                    $display("%0t: was_remembered expected %b actual %b",
                             $time, want.hit, was_remembered);
                    errors++;
                end
                if (table_full !== want.full)
                begin
                    $display("%0t: table_full expected %b actual %b",
                             $time, want.full, table_full);
                    errors++;
                end
            end
            taken++;
            @(negedge clk);
        end
    end

    // Watchdog: too long without a beat on either side means the block hung.
    int idle_cycles = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= STALL_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, owed_grants.size());
                $display("status: fail");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
